/* src/pnv_pkg.sv */
// ----------------------------------------------------------------------------
// pnv_pkg: shared types, constants and helpers of the personal number validator
// holds the digit types, month lengths, check weights and the mod-11 reduction
// ----------------------------------------------------------------------------
`default_nettype none

package pnv_pkg;

   localparam int NUM_DIGITS   = 10;
   localparam int NUM_WEIGHTED = 9;
   localparam int DIGIT_W      = 4;
   localparam int SUM_W        = 9;   // 9 * 6 * 9 at most, below 512
   localparam int MONTHS       = 12;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [NUM_DIGITS-1:0] digit_vec_type;   // entry 0 is digit_1

   // per-item verdict from the check logic
   typedef struct packed {
      logic digits_ok;
      logic date_ok;
      logic sum_ok;
   } check_type;

   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

   localparam logic [4:0] MONTH_DAYS [MONTHS] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   localparam logic [3:0] DIGIT_WEIGHT [NUM_WEIGHTED] = '{
      4'd2, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 4'd7, 4'd3, 4'd6
   };

   localparam logic [SUM_W-1:0] CHECK_MOD = 9'd11;
   // reciprocal of eleven scaled by 2**12, exact for all sums below 512
   localparam int RECIP_SHIFT = 12;
   localparam logic [8:0] RECIP_11 = 9'd373;

   // month length, zero for a month outside 1..12
   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [3:0] idx;
      logic [4:0] days;
      idx  = month - 4'd1;
      days = 5'd0;
      if (month >= 4'd1 && month <= 4'(MONTHS)) begin
         days = MONTH_DAYS[idx];
      end
      if (month == MONTH_FEB && leap) begin
         days = FEB_LEAP_DAYS;
      end
      return days;
   endfunction

   // remainder by eleven through the scaled reciprocal and one correction-free subtract
   function automatic logic [3:0] mod11(input logic [SUM_W-1:0] sum);
      logic [SUM_W+8:0] prod;
      logic [SUM_W-1:0] quot;
      logic [SUM_W-1:0] rem;
      prod = (SUM_W+9)'(sum) * (SUM_W+9)'(RECIP_11);
      quot = SUM_W'(prod >> RECIP_SHIFT);
      rem  = sum - SUM_W'(quot * CHECK_MOD);
      return rem[3:0];
   endfunction

endpackage

`default_nettype wire

/* src/pnv_if.sv */
// ----------------------------------------------------------------------------
// pnv channel interfaces
// valid/ready channels for the digit request and the verdict response
// ----------------------------------------------------------------------------
`default_nettype none

interface pnv_req_if;
   logic                valid;
   logic                ready;
   pnv_pkg::digit_type  digit_1;
   pnv_pkg::digit_type  digit_2;
   pnv_pkg::digit_type  digit_3;
   pnv_pkg::digit_type  digit_4;
   pnv_pkg::digit_type  digit_5;
   pnv_pkg::digit_type  digit_6;
   pnv_pkg::digit_type  digit_7;
   pnv_pkg::digit_type  digit_8;
   pnv_pkg::digit_type  digit_9;
   pnv_pkg::digit_type  digit_10;

   modport source (
      output valid, digit_1, digit_2, digit_3, digit_4, digit_5,
             digit_6, digit_7, digit_8, digit_9, digit_10,
      input  ready
   );
   modport sink (
      input  valid, digit_1, digit_2, digit_3, digit_4, digit_5,
             digit_6, digit_7, digit_8, digit_9, digit_10,
      output ready
   );
endinterface

interface pnv_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source (output valid, valid_res, input ready);
   modport sink (input valid, valid_res, output ready);
endinterface

`default_nettype wire

/* src/pnv_check.sv */
// ----------------------------------------------------------------------------
// pnv_check: digit, date and check-digit tests
// pure logic between the input register and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module pnv_check (
   input  wire pnv_pkg::digit_vec_type digits,
   output pnv_pkg::check_type          verdict
);

   logic [6:0]                 year;
   logic [6:0]                 month_raw;
   logic [6:0]                 month_adj;
   logic [6:0]                 day;
   logic                       month_ok;
   logic [4:0]                 limit;
   logic [pnv_pkg::SUM_W-1:0]  sum;
   logic [3:0]                 rem;
   logic [3:0]                 check;
   logic                       digits_ok;
   logic                       date_ok;
   logic                       sum_ok;

   always_comb begin
      digits_ok = 1'b1;
      for (int i = 0; i < pnv_pkg::NUM_DIGITS; i++) begin
         if (digits[i] > pnv_pkg::DIGIT_MAX) begin
            digits_ok = 1'b0;
         end
      end
   end

   assign year      = 7'(digits[0]) * 7'd10 + 7'(digits[1]);
   assign month_raw = 7'(digits[2]) * 7'd10 + 7'(digits[3]);
   assign day       = 7'(digits[4]) * 7'd10 + 7'(digits[5]);

   // century offsets on the month code
   always_comb begin
      if (month_raw >= 7'd21 && month_raw <= 7'd32) begin
         month_adj = month_raw - 7'd20;
      end else if (month_raw >= 7'd41 && month_raw <= 7'd52) begin
         month_adj = month_raw - 7'd40;
      end else begin
         month_adj = month_raw;
      end
   end

   assign month_ok = (month_adj >= 7'd1) && (month_adj <= 7'(pnv_pkg::MONTHS));
   assign limit    = pnv_pkg::month_length(month_adj[3:0], year[1:0] == 2'd0);
   assign date_ok  = month_ok && (day >= 7'd1) && (day <= 7'(limit));

   always_comb begin
      sum = '0;
      for (int i = 0; i < pnv_pkg::NUM_WEIGHTED; i++) begin
         sum = sum + pnv_pkg::SUM_W'(digits[i]) * pnv_pkg::SUM_W'(pnv_pkg::DIGIT_WEIGHT[i]);
      end
   end

   assign rem    = pnv_pkg::mod11(sum);
   assign check  = (rem == 4'd10) ? 4'd0 : rem;
   assign sum_ok = (check == digits[pnv_pkg::NUM_DIGITS-1]);

   assign verdict = '{digits_ok: digits_ok, date_ok: date_ok, sum_ok: sum_ok};

endmodule

`default_nettype wire

/* src/personal_number_validator.sv */
// ----------------------------------------------------------------------------
// personal_number_validator: ten-digit personal identity number check
// tests digit range, coded month with century offset, day against month
// length (leap february) and the weighted mod-11 check digit
// ----------------------------------------------------------------------------
//
//  channel   dir   beat contents
//  -------   ---   ------------------------------------------
//  req_bus   in    digit_1 .. digit_10, four bits each
//  rsp_bus   out   valid_res, one bit per request beat
//
//  two register stages: a request beat lands in the input register at its
//  accepting edge and its verdict moves into the result register once that
//  register is free or draining, and is offered on rsp_bus from there
//  one beat a cycle sustained while rsp_bus.ready holds; the only path is
//  the check logic between the two registers
//  a stalled response holds the result register, the input register still
//  takes a beat if it is empty, back pressure then reaches req_bus.ready
//  synchronous active-high reset empties both stages, no payload is cleared
// ----------------------------------------------------------------------------
`default_nettype none

module personal_number_validator (
   input  wire        clock,
   input  wire        reset,
   pnv_req_if.sink    req_bus,
   pnv_rsp_if.source  rsp_bus
);

   // input stage
   logic                    s1_valid_ff, s1_valid_in;
   pnv_pkg::digit_vec_type  s1_digits_ff;
   pnv_pkg::digit_vec_type  req_digits;

   // result stage
   logic                    s2_valid_ff, s2_valid_in;
   logic                    res_ff;

   logic                    s2_open;
   logic                    s1_adv;
   logic                    req_fire;
   pnv_pkg::check_type      verdict;

   // gather the request digits, digit_1 at entry 0
   assign req_digits[0] = req_bus.digit_1;
   assign req_digits[1] = req_bus.digit_2;
   assign req_digits[2] = req_bus.digit_3;
   assign req_digits[3] = req_bus.digit_4;
   assign req_digits[4] = req_bus.digit_5;
   assign req_digits[5] = req_bus.digit_6;
   assign req_digits[6] = req_bus.digit_7;
   assign req_digits[7] = req_bus.digit_8;
   assign req_digits[8] = req_bus.digit_9;
   assign req_digits[9] = req_bus.digit_10;

   // result register free or draining this cycle
   assign s2_open       = !s2_valid_ff || rsp_bus.ready;
   assign s1_adv        = s1_valid_ff && s2_open;
   assign req_bus.ready = !s1_valid_ff || s2_open;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_digits_ff <= req_digits;
      end
      if (s1_adv) begin
         res_ff <= verdict.digits_ok && verdict.date_ok && verdict.sum_ok;
      end
   end

   pnv_check u_check (
      .digits  (s1_digits_ff),
      .verdict (verdict)
   );

   assign rsp_bus.valid     = s2_valid_ff;
   assign rsp_bus.valid_res = res_ff;

   // a request taken always lands in the input stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request beat lost from input stage");

   // an advancing beat always lands in the result stage
   a_adv_lands: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff)
      else $error("checked beat lost from result stage");

   // a non-decimal digit can never produce a pass
   a_bad_digit: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !verdict.digits_ok) |=> !res_ff)
      else $error("pass reported for non-decimal digit");

   // an empty input stage never stalls the request side
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_bus.ready)
      else $error("request stalled with empty input stage");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: personal number validator
// drives ten-digit beats through the request channel and checks each verdict
// beat against a behavioural predictor; a short table of directed numbers
// comes first, then about six hundred random numbers in three idling phases
// ----------------------------------------------------------------------------

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // timing of the run
   localparam int CLOCK_HALF_NS    = 10;
   localparam int RESET_CYCLES     = 8;
   localparam int TAIL_CYCLES      = 8;          // two register stages, with margin
   localparam int RUN_LIMIT_NS     = 2_000_000;  // far beyond the slowest correct run
   localparam int RANDOM_PER_PHASE = 200;
   localparam int REPORT_LIMIT     = 10;

   // number format: month lengths, century offsets and the check digit weights
   localparam int unsigned FEBRUARY      = 2;
   localparam int unsigned LEAP_FEB_DAYS = 29;
   localparam int unsigned CENTURY_A     = 20;   // coded months 21..32
   localparam int unsigned CENTURY_B     = 40;   // coded months 41..52
   localparam int unsigned CHECK_MODULUS = 11;
   localparam int unsigned MONTH_LENGTHS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned CHECK_WEIGHTS [9]  = '{2, 4, 8, 5, 10, 9, 7, 3, 6};

   // one row of the directed table: digits as nibbles, digit_1 in the top one;
   // a fixed row carries its verdict, the others go through the predictor
   typedef struct packed {
      logic [39:0] number;
      bit          fixed;
      bit          verdict;
   } vector_row_type;

   localparam int NUM_VECTORS = 25;
   localparam vector_row_type DIRECTED_VECTORS [NUM_VECTORS] = '{
      '{40'h0000000000, 1'b1, 1'b0},   // month zero
      '{40'hFFFFFFFFFF, 1'b1, 1'b0},   // every nibble above nine
      '{40'h9999999999, 1'b1, 1'b0},   // month code 99
      '{40'h7501020018, 1'b0, 1'b0},   // ordinary good number
      '{40'h7501020019, 1'b0, 1'b0},   // same, check digit off by one
      '{40'h0013010000, 1'b1, 1'b0},   // first unused code above december
      '{40'h0020010000, 1'b1, 1'b0},   // last code of the first unused range
      '{40'h0021010008, 1'b0, 1'b0},   // lowest code of the 20 offset
      '{40'h0032310007, 1'b0, 1'b0},   // december 31 with the 20 offset
      '{40'h0033010000, 1'b1, 1'b0},   // second unused range, low end
      '{40'h0040010000, 1'b1, 1'b0},   // second unused range, high end
      '{40'h0041010002, 1'b0, 1'b0},   // lowest code of the 40 offset
      '{40'h0052310001, 1'b0, 1'b0},   // december 31 with the 40 offset
      '{40'h0053010000, 1'b1, 1'b0},   // first code past the 40 offset
      '{40'h0001000000, 1'b1, 1'b0},   // day zero
      '{40'h0002290001, 1'b0, 1'b0},   // 29 february, year 00 is a leap year
      '{40'h0102290000, 1'b1, 1'b0},   // 29 february, not a leap year
      '{40'h0102280007, 1'b0, 1'b0},   // 28 february, not a leap year
      '{40'h0004310000, 1'b1, 1'b0},   // 31 april
      '{40'h0004300006, 1'b0, 1'b0},   // 30 april
      '{40'h0001320000, 1'b1, 1'b0},   // 32 january
      '{40'h0001010030, 1'b0, 1'b0},   // weighted sum leaves ten, check digit zero
      '{40'h000101003A, 1'b1, 1'b0},   // check digit above nine
      '{40'h00010100A0, 1'b1, 1'b0},   // serial digit above nine
      '{40'h9912310001, 1'b0, 1'b0}    // highest year, last day of the year
   };

   logic clock;
   logic reset;

   pnv_req_if req_bus ();
   pnv_rsp_if rsp_bus ();

   personal_number_validator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // verdicts still owed by the block, oldest first
   bit pending_verdicts [$];
   int mismatch_count;

   // idling rates in percent, changed per phase by the stimulus thread
   int unsigned sender_gap_pct;
   int unsigned receiver_stall_pct;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // days in a month 1..12 for a two-digit year
   function automatic int unsigned days_in_month(input int unsigned month,
                                                 input int unsigned year);
      if (month == FEBRUARY && (year % 4) == 0) begin
         return LEAP_FEB_DAYS;
      end
      return MONTH_LENGTHS[month - 1];
   endfunction

   // check digit over digits 1..9, a remainder of ten folds to zero
   function automatic pnv_pkg::digit_type check_digit(input pnv_pkg::digit_vec_type d);
      int unsigned acc;
      acc = 0;
      for (int i = 0; i < 9; i++) begin
         acc += CHECK_WEIGHTS[i] * d[i];
      end
      acc %= CHECK_MODULUS;
      return (acc == CHECK_MODULUS - 1) ? pnv_pkg::digit_type'(0)
                                        : pnv_pkg::digit_type'(acc);
   endfunction

   function automatic bit predict_verdict(input pnv_pkg::digit_vec_type d);
      int unsigned year;
      int unsigned code;
      int unsigned month;
      int unsigned day;
      foreach (d[i]) begin
         if (d[i] > pnv_pkg::DIGIT_MAX) begin
            return 1'b0;
         end
      end
      year = d[0] * 10 + d[1];
      code = d[2] * 10 + d[3];
      day  = d[4] * 10 + d[5];
      // strip the century offset from the coded month
      if (code >= CENTURY_A + 1 && code <= CENTURY_A + 12) begin
         month = code - CENTURY_A;
      end else if (code >= CENTURY_B + 1 && code <= CENTURY_B + 12) begin
         month = code - CENTURY_B;
      end else begin
         month = code;
      end
      if (month < 1 || month > 12) begin
         return 1'b0;
      end
      if (day < 1 || day > days_in_month(month, year)) begin
         return 1'b0;
      end
      return check_digit(d) == d[9];
   endfunction

   // ---------------------------------------------------------------------
   // random numbers: a quarter noise, a fifth with a broken date, a tenth with
   // a wrong check digit, the rest well-formed with a correct check digit
   // ---------------------------------------------------------------------
   function automatic pnv_pkg::digit_vec_type random_number();
      pnv_pkg::digit_vec_type d;
      int unsigned            pick;
      int unsigned            year;
      int unsigned            month;
      int unsigned            code;
      int unsigned            day;
      int unsigned            limit;
      bit                     wide;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         // noise, half of it with nibbles above nine allowed
         wide = $urandom_range(0, 1);
         foreach (d[i]) begin
            d[i] = wide ? pnv_pkg::digit_type'($urandom_range(0, 15))
                        : pnv_pkg::digit_type'($urandom_range(0, 9));
         end
         return d;
      end
      year  = $urandom_range(0, 99);
      month = ($urandom_range(0, 5) == 0) ? FEBRUARY : $urandom_range(1, 12);
      limit = days_in_month(month, year);
      // month ends are where the date check bites, so favour them
      day   = ($urandom_range(0, 3) == 0) ? limit : $urandom_range(1, limit);
      case ($urandom_range(0, 2))
         0: code = month;
         1: code = month + CENTURY_A;
         default: code = month + CENTURY_B;
      endcase
      if (pick < 45) begin
         // broken date: day just past the month, day zero or an unused month code
         case ($urandom_range(0, 2))
            0: day = limit + 1;
            1: day = 0;
            default: begin
               case ($urandom_range(0, 3))
                  0: code = 0;
                  1: code = $urandom_range(13, 20);
                  2: code = $urandom_range(33, 40);
                  default: code = $urandom_range(53, 99);
               endcase
            end
         endcase
      end
      d[0] = pnv_pkg::digit_type'(year / 10);
      d[1] = pnv_pkg::digit_type'(year % 10);
      d[2] = pnv_pkg::digit_type'(code / 10);
      d[3] = pnv_pkg::digit_type'(code % 10);
      d[4] = pnv_pkg::digit_type'(day / 10);
      d[5] = pnv_pkg::digit_type'(day % 10);
      for (int i = 6; i < 9; i++) begin
         d[i] = pnv_pkg::digit_type'($urandom_range(0, 9));
      end
      d[9] = check_digit(d);
      // a share of the otherwise good numbers get a wrong check digit
      if (pick >= 45 && pick < 55) begin
         d[9] = pnv_pkg::digit_type'((d[9] + $urandom_range(1, 9)) % 10);
      end
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // present one number, hold it until the block takes the beat, then
   // record the verdict it is owed
   task automatic send_number(input pnv_pkg::digit_vec_type d, input bit fixed,
                              input bit verdict);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.digit_1  <= d[0];
      req_bus.digit_2  <= d[1];
      req_bus.digit_3  <= d[2];
      req_bus.digit_4  <= d[3];
      req_bus.digit_5  <= d[4];
      req_bus.digit_6  <= d[5];
      req_bus.digit_7  <= d[6];
      req_bus.digit_8  <= d[7];
      req_bus.digit_9  <= d[8];
      req_bus.digit_10 <= d[9];
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      pending_verdicts.push_back(fixed ? verdict : predict_verdict(d));
   endtask

   // stop sending and let every owed verdict come back
   task automatic wait_for_verdicts();
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // clock, reset and the stimulus thread
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever begin
         #(CLOCK_HALF_NS) clock = ~clock;
      end
   end

   // absolute limit, in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

   // receiver readiness, redrawn every cycle
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   initial begin
      pnv_pkg::digit_vec_type d;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.digit_1    = '0;
      req_bus.digit_2    = '0;
      req_bus.digit_3    = '0;
      req_bus.digit_4    = '0;
      req_bus.digit_5    = '0;
      req_bus.digit_6    = '0;
      req_bus.digit_7    = '0;
      req_bus.digit_8    = '0;
      req_bus.digit_9    = '0;
      req_bus.digit_10   = '0;
      rsp_bus.ready      = 1'b0;
      mismatch_count     = 0;
      sender_gap_pct     = 12;
      receiver_stall_pct = 52;

      repeat (RESET_CYCLES) begin
         @(posedge clock);
      end
      reset <= 1'b0;

      // directed table, under the first idling setting
      for (int row = 0; row < NUM_VECTORS; row++) begin
         for (int j = 0; j < 10; j++) begin
            d[j] = DIRECTED_VECTORS[row].number[39 - 4 * j -: 4];
         end
         send_number(d, DIRECTED_VECTORS[row].fixed, DIRECTED_VECTORS[row].verdict);
      end
      // hold off until the pipe is empty before the random part
      wait_for_verdicts();

      // random part: receiver stalls then sender gaps dominate, then neither
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_gap_pct     = 12;
               receiver_stall_pct = 52;
            end
            1: begin
               sender_gap_pct     = 52;
               receiver_stall_pct = 12;
            end
            default: begin
               sender_gap_pct     = 0;
               receiver_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            send_number(random_number(), 1'b0, 1'b0);
         end
         wait_for_verdicts();
      end

      // any stray verdict beat in the tail is caught by the checker
      repeat (TAIL_CYCLES) begin
         @(posedge clock);
      end

      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // verdict checker: every accepted beat against the oldest owed verdict
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : verdict_check
      bit owed;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%t: verdict beat %0b with nothing owed", $realtime, rsp_bus.valid_res);
            end
         end else begin
            owed = pending_verdicts.pop_front();
            if (rsp_bus.valid_res !== owed) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%t: valid_res mismatch, expected %0b, got %0b",
                           $realtime, owed, rsp_bus.valid_res);
               end
            end
         end
      end
   end

endmodule
